// File: hdl/wsts_pkg.sv
// Shared types and constants of the weighted sum-tree sampler.
// Used by the controller, the datapath, the top level and the checker.
package wsts_pkg;

  localparam int ID_BITS       = 10;
  localparam int SUM_BITS      = 42;
  localparam int IN_WGT_BITS   = 32;
  localparam int CFG_BITS      = 11;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam int IN_NODE_LSB   = 0;
  localparam int IN_WGT_LSB    = IN_NODE_LSB + ID_BITS;
  localparam int IN_POS_LSB    = IN_WGT_LSB + IN_WGT_BITS;
  localparam int IN_START_LSB  = IN_POS_LSB + SUM_BITS;
  localparam int IN_USED_BITS  = IN_START_LSB + ID_BITS;
  localparam int IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;

  localparam int OUT_FOUND_LSB = 0;
  localparam int OUT_TOTAL_LSB = OUT_FOUND_LSB + ID_BITS;
  localparam int OUT_USED_BITS = OUT_TOTAL_LSB + SUM_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 11'd1024;
  localparam logic [0:0]          REG_ACTIVE   = 1'b0;

  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_FIND = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_POS  = 2'd1,
    ST_NODE = 2'd2
  } status_t;

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_DISPATCH = 12'b000000000100,
    S_SET_W    = 12'b000000001000,
    S_SET_RD   = 12'b000000010000,
    S_SET_WB   = 12'b000000100000,
    S_FND_RD0  = 12'b000001000000,
    S_FND_CHK  = 12'b000010000000,
    S_FND_RD   = 12'b000100000000,
    S_FND_EV1  = 12'b001000000000,
    S_FND_EV2  = 12'b010000000000,
    S_DONE     = 12'b100000000000
  } state_t;

  typedef struct packed {
    logic    clear;
    logic    load;
    logic    wr_weight;
    logic    rd_node;
    logic    rd_root;
    logic    wb_sum;
    logic    ev1;
    logic    ev2;
    logic    finish;
    logic    found_ok;
    status_t res;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_find;
    logic node_ok;
    logic is_root;
    logic pos_below;
    logic take_node;
    logic go_left;
    logic go_right;
  } stat_t;

endpackage

// File: hdl/weighted_sum_tree_sampler_unit.sv
// Weighted sum-tree sampler, top level: stream ports, APB register and the
// controller/datapath pair. Depends on wsts_pkg, wsts_ctrl and wsts_datapath.
//
// After reset the block clears both tree memories and accepts no beat
// meanwhile; the register port works throughout. The block takes one item
// at a time. A set of a node writes its weight, then does the read and
// the write-back of each subtree sum on the way to the root. A find that
// descends below its start node takes a memory read and two compare steps
// per level. Items for an inactive node are rejected without a walk. A
// finished result waits in the output register while the next item is
// already being worked on.
module weighted_sum_tree_sampler_unit #(
  parameter int MAX_ENTRIES = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // node_id, new_weight, position, start_node, zero pad
  input  logic [wsts_pkg::IN_DATA_BITS-1:0]      in_tdata,
  // func
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // found_node, total_weight, zero pad
  output logic [wsts_pkg::OUT_DATA_BITS-1:0]     out_tdata,
  // status
  output logic [1:0]                             out_tuser,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [wsts_pkg::CFG_ADDR_BITS-1:0]     cfg_paddr,
  input  logic [wsts_pkg::CFG_DATA_BITS-1:0]     cfg_pwdata,
  output logic [wsts_pkg::CFG_DATA_BITS-1:0]     cfg_prdata,
  output logic                                   cfg_pready
);

  logic [wsts_pkg::CFG_BITS-1:0] active_r;
  logic                          reg_sel;
  wsts_pkg::cmd_t                cmd;
  wsts_pkg::stat_t               stat;
  logic [wsts_pkg::ID_BITS-1:0]  found_node;
  logic [wsts_pkg::SUM_BITS-1:0] total_weight;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[wsts_pkg::CFG_ADDR_BITS-1] == wsts_pkg::REG_ACTIVE);
  assign cfg_prdata = reg_sel ? wsts_pkg::CFG_DATA_BITS'(active_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= wsts_pkg::ACTIVE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      active_r <= cfg_pwdata[wsts_pkg::CFG_BITS-1:0];
    end
  end

  wsts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  wsts_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .active_entries   (active_r),
    .in_func          (in_tuser),
    .in_node_id       (in_tdata[wsts_pkg::IN_NODE_LSB +: wsts_pkg::ID_BITS]),
    .in_new_weight    (in_tdata[wsts_pkg::IN_WGT_LSB +: wsts_pkg::IN_WGT_BITS]),
    .in_position      (in_tdata[wsts_pkg::IN_POS_LSB +: wsts_pkg::SUM_BITS]),
    .in_start_node    (in_tdata[wsts_pkg::IN_START_LSB +: wsts_pkg::ID_BITS]),
    .cmd              (cmd),
    .stat             (stat),
    .out_found_node   (found_node),
    .out_total_weight (total_weight),
    .out_status       (out_tuser)
  );

  assign out_tdata = wsts_pkg::OUT_DATA_BITS'({total_weight, found_node});

endmodule

// File: hdl/wsts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module wsts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/wsts_datapath.sv
// Datapath of the sum-tree sampler: node weight and subtree sum memories,
// the walk registers and the result register. Depends on wsts_pkg and wsts_ram.
module wsts_datapath #(
  parameter int MAX_ENTRIES = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [wsts_pkg::CFG_BITS-1:0]       active_entries,
  input  logic                                in_func,
  input  logic [wsts_pkg::ID_BITS-1:0]        in_node_id,
  input  logic [wsts_pkg::IN_WGT_BITS-1:0]    in_new_weight,
  input  logic [wsts_pkg::SUM_BITS-1:0]       in_position,
  input  logic [wsts_pkg::ID_BITS-1:0]        in_start_node,
  input  wsts_pkg::cmd_t                      cmd,
  output wsts_pkg::stat_t                     stat,
  output logic [wsts_pkg::ID_BITS-1:0]        out_found_node,
  output logic [wsts_pkg::SUM_BITS-1:0]       out_total_weight,
  output logic [1:0]                          out_status
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = AW + 2;
  localparam int SW = (CW > wsts_pkg::CFG_BITS) ? CW : wsts_pkg::CFG_BITS;
  localparam int EW = (WEIGHT_BITS > wsts_pkg::SUM_BITS) ? WEIGHT_BITS : wsts_pkg::SUM_BITS;
  localparam int XW = (WEIGHT_BITS > wsts_pkg::IN_WGT_BITS) ? WEIGHT_BITS
                                                             : wsts_pkg::IN_WGT_BITS;
  localparam int SB = wsts_pkg::SUM_BITS;
  localparam logic [SW-1:0] MAX_SIZE = SW'(MAX_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);

  logic [SW-1:0]          node_r;
  logic [SB-1:0]          pos_r;
  logic [WEIGHT_BITS-1:0] wgt_r;
  logic                   is_find_r;
  logic                   lv_r;
  logic                   rv_r;
  logic [SB-1:0]          ls_r;
  logic [SB:0]            lrs_r;
  logic [SB-1:0]          total_r;
  logic [AW-1:0]          clr_addr_r;
  logic [wsts_pkg::ID_BITS-1:0] found_r;
  logic [SB-1:0]          out_total_r;
  wsts_pkg::status_t      status_r;

  logic [SW-1:0]          size;
  logic [SW-1:0]          left;
  logic [SW-1:0]          right;
  logic [SW-1:0]          parent;
  logic [XW-1:0]          wgt_wide;
  logic [WEIGHT_BITS-1:0] w_rdata;
  logic [SB-1:0]          a_rdata;
  logic [SB-1:0]          b_rdata;
  logic [SB-1:0]          ls;
  logic [SB-1:0]          rs;
  logic [SB:0]            lrs;
  logic [EW+1:0]          sum_wide;
  logic [SB-1:0]          new_sum;
  logic [EW-1:0]          p1_wide;
  logic                   w_we;
  logic                   s_we;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          a_raddr;

  assign size     = (SW'(active_entries) > MAX_SIZE) ? MAX_SIZE : SW'(active_entries);
  assign left     = SW'({node_r, 1'b0}) + SW'(1);
  assign right    = SW'({node_r, 1'b0}) + SW'(2);
  assign parent   = (node_r - SW'(1)) >> 1;
  assign wgt_wide = XW'(in_new_weight);

  assign ls       = lv_r ? a_rdata : '0;
  assign rs       = rv_r ? b_rdata : '0;
  assign lrs      = {1'b0, ls} + {1'b0, rs};
  assign sum_wide = (EW+2)'(w_rdata) + (EW+2)'(ls) + (EW+2)'(rs);
  assign new_sum  = sum_wide[SB-1:0];
  assign p1_wide  = EW'(pos_r) - EW'(w_rdata);

  assign w_we    = cmd.clear | cmd.wr_weight;
  assign s_we    = cmd.clear | cmd.wb_sum;
  assign waddr   = cmd.clear ? clr_addr_r : node_r[AW-1:0];
  assign a_raddr = cmd.rd_root ? node_r[AW-1:0] : left[AW-1:0];

  wsts_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ENTRIES)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (waddr),
    .wdata (cmd.clear ? '0 : wgt_r),
    .raddr (node_r[AW-1:0]),
    .rdata (w_rdata)
  );

  wsts_ram #(.WIDTH(SB), .DEPTH(MAX_ENTRIES)) u_sum_ram_a (
    .clk   (clk),
    .we    (s_we),
    .waddr (waddr),
    .wdata (cmd.clear ? '0 : new_sum),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  wsts_ram #(.WIDTH(SB), .DEPTH(MAX_ENTRIES)) u_sum_ram_b (
    .clk   (clk),
    .we    (s_we),
    .waddr (waddr),
    .wdata (cmd.clear ? '0 : new_sum),
    .raddr (right[AW-1:0]),
    .rdata (b_rdata)
  );

  always_comb begin
    stat           = '0;
    stat.clr_last  = (clr_addr_r == LAST_ADDR);
    stat.is_find   = is_find_r;
    stat.node_ok   = (node_r < size);
    stat.is_root   = (node_r == '0);
    stat.pos_below = (pos_r < a_rdata);
    stat.take_node = (EW'(pos_r) < EW'(w_rdata));
    stat.go_left   = (pos_r < ls_r);
    stat.go_right  = ({1'b0, pos_r} < lrs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      total_r    <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        total_r    <= '0;
      end
      if (cmd.wb_sum && (node_r == '0)) begin
        total_r <= new_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_r    <= (in_func == wsts_pkg::FUNC_FIND) ? SW'(in_start_node) : SW'(in_node_id);
      pos_r     <= in_position;
      wgt_r     <= wgt_wide[WEIGHT_BITS-1:0];
      is_find_r <= in_func;
    end
    if (cmd.rd_node) begin
      lv_r <= (left < size);
      rv_r <= (right < size);
    end
    if (cmd.wb_sum && (node_r != '0)) begin
      node_r <= parent;
    end
    if (cmd.ev1) begin
      pos_r <= p1_wide[SB-1:0];
      ls_r  <= ls;
      lrs_r <= lrs;
    end
    if (cmd.ev2) begin
      if (pos_r < ls_r) begin
        node_r <= left;
      end else if ({1'b0, pos_r} < lrs_r) begin
        node_r <= right;
        pos_r  <= pos_r - ls_r;
      end
    end
    if (cmd.finish) begin
      found_r     <= cmd.found_ok ? node_r[wsts_pkg::ID_BITS-1:0] : '0;
      out_total_r <= total_r;
      status_r    <= cmd.res;
    end
  end

  assign out_found_node   = found_r;
  assign out_total_weight = out_total_r;
  assign out_status       = status_r;

endmodule

// File: hdl/wsts_ctrl.sv
// Controller of the sum-tree sampler: sequences clearing, set walks and find
// descents, and owns the input and output handshakes. Depends on wsts_pkg.
module wsts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output wsts_pkg::cmd_t  cmd,
  input  wsts_pkg::stat_t stat
);

  wsts_pkg::state_t  state_r, state_nxt;
  wsts_pkg::status_t res_r, res_nxt;
  logic              found_ok_r, found_ok_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    found_ok_nxt  = found_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.res       = res_r;
    cmd.found_ok  = found_ok_r;
    unique case (state_r)
      wsts_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = wsts_pkg::S_IDLE;
        end
      end
      wsts_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = wsts_pkg::S_DISPATCH;
        end
      end
      wsts_pkg::S_DISPATCH: begin
        found_ok_nxt = 1'b0;
        res_nxt      = wsts_pkg::ST_OK;
        if (!stat.node_ok) begin
          res_nxt   = wsts_pkg::ST_NODE;
          state_nxt = wsts_pkg::S_DONE;
        end else if (stat.is_find) begin
          state_nxt = wsts_pkg::S_FND_RD0;
        end else begin
          state_nxt = wsts_pkg::S_SET_W;
        end
      end
      wsts_pkg::S_SET_W: begin
        cmd.wr_weight = 1'b1;
        state_nxt     = wsts_pkg::S_SET_RD;
      end
      wsts_pkg::S_SET_RD: begin
        cmd.rd_node = 1'b1;
        state_nxt   = wsts_pkg::S_SET_WB;
      end
      wsts_pkg::S_SET_WB: begin
        cmd.wb_sum = 1'b1;
        state_nxt  = stat.is_root ? wsts_pkg::S_DONE : wsts_pkg::S_SET_RD;
      end
      wsts_pkg::S_FND_RD0: begin
        cmd.rd_root = 1'b1;
        state_nxt   = wsts_pkg::S_FND_CHK;
      end
      wsts_pkg::S_FND_CHK: begin
        if (stat.pos_below) begin
          state_nxt = wsts_pkg::S_FND_RD;
        end else begin
          res_nxt   = wsts_pkg::ST_POS;
          state_nxt = wsts_pkg::S_DONE;
        end
      end
      wsts_pkg::S_FND_RD: begin
        cmd.rd_node = 1'b1;
        state_nxt   = wsts_pkg::S_FND_EV1;
      end
      wsts_pkg::S_FND_EV1: begin
        if (stat.take_node) begin
          found_ok_nxt = 1'b1;
          state_nxt    = wsts_pkg::S_DONE;
        end else begin
          cmd.ev1   = 1'b1;
          state_nxt = wsts_pkg::S_FND_EV2;
        end
      end
      wsts_pkg::S_FND_EV2: begin
        cmd.ev2 = 1'b1;
        if (stat.go_left || stat.go_right) begin
          state_nxt = wsts_pkg::S_FND_RD;
        end else begin
          res_nxt   = wsts_pkg::ST_POS;
          state_nxt = wsts_pkg::S_DONE;
        end
      end
      wsts_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = wsts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wsts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsts_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
      res_r       <= wsts_pkg::ST_OK;
      found_ok_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
      found_ok_r  <= found_ok_nxt;
    end
  end

  assign in_tready  = (state_r == wsts_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// File: hdl/wsts_checker.sv
// Port-level assertions for the sum-tree sampler and the bind that attaches
// them to the top level. Depends on wsts_pkg and weighted_sum_tree_sampler_unit.
module wsts_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [wsts_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic [1:0]                         out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Result beat dropped before it was taken.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("Result beat changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("A second item was accepted while one is in progress.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == wsts_pkg::ST_OK) || (out_tuser == wsts_pkg::ST_POS) ||
                   (out_tuser == wsts_pkg::ST_NODE))
    else $error("Result status is not a defined code.");

  a_error_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != wsts_pkg::ST_OK)
      |-> (out_tdata[wsts_pkg::OUT_FOUND_LSB +: wsts_pkg::ID_BITS] == '0))
    else $error("Failed item reports a nonzero found node.");

endmodule

bind weighted_sum_tree_sampler_unit wsts_checker u_wsts_checker (.*);
